// ===== hdl/nrm_pkg.sv =====
// Shared types and constants for the NFA regex match step block.
// Used by the controller, the datapath and the top level; depends on nothing.
package nrm_pkg;

  localparam int SYM_W  = 9;
  localparam int SUCC_W = 7;
  localparam int IDX_W  = 6;

  localparam logic [SYM_W-1:0] SYM_SPLIT = 9'd256;
  localparam logic [SYM_W-1:0] SYM_MATCH = 9'd257;
  localparam logic [SYM_W-1:0] SYM_WILD  = 9'd46;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_CHAR  = 2'd2
  } action_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clear;
    logic cand_start;
    logic cand_n1;
    logic cand_n2;
    logic push;
    logic pop;
    logic rd_scan;
    logic rd_cur;
    logic keep;
    logic scan_inc;
    logic commit;
  } nrm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stack_empty;
    logic hit;
    logic split;
    logic scan_last;
  } nrm_sts_t;

endpackage

// ===== hdl/nrm_ctrl.sv =====
// Controller state machine of the NFA regex match step block.
// Sequences the table scan and the closure; depends on nrm_pkg.
module nrm_ctrl import nrm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_action,
  input  nrm_sts_t   sts,
  output logic       busy,
  output nrm_cmd_t   cmd,
  output logic       out_strobe
);

  typedef enum logic [3:0] {
    IDLE,
    SCAN_RD,
    SCAN_CHK,
    SCAN_NEXT,
    PUSH_A,
    PUSH_B,
    POP,
    CUR_RD,
    CUR_CHK,
    COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   char_mode_r, char_mode_nxt;
  logic   out_strobe_r;

  assign busy       = (state_r != IDLE);
  assign out_strobe = out_strobe_r;

  always_comb begin
    state_nxt     = state_r;
    char_mode_nxt = char_mode_r;
    cmd           = '0;
    unique case (state_r)
      IDLE: begin
        if (start) begin
          unique case (action_t'(in_action))
            ACT_LOAD: cmd.load = 1'b1;
            ACT_START: begin
              cmd.clear      = 1'b1;
              cmd.cand_start = 1'b1;
              char_mode_nxt  = 1'b0;
              state_nxt      = PUSH_B;
            end
            ACT_CHAR: begin
              cmd.clear     = 1'b1;
              char_mode_nxt = 1'b1;
              state_nxt     = SCAN_RD;
            end
            default: ;
          endcase
        end
      end
      SCAN_RD: begin
        cmd.rd_scan = 1'b1;
        state_nxt   = SCAN_CHK;
      end
      SCAN_CHK: begin
        if (sts.hit) begin
          cmd.cand_n1 = 1'b1;
          state_nxt   = PUSH_B;
        end else begin
          state_nxt = SCAN_NEXT;
        end
      end
      SCAN_NEXT: begin
        if (sts.scan_last) begin
          state_nxt = COMMIT;
        end else begin
          cmd.scan_inc = 1'b1;
          state_nxt    = SCAN_RD;
        end
      end
      PUSH_A: begin
        cmd.push    = 1'b1;
        cmd.cand_n2 = 1'b1;
        state_nxt   = PUSH_B;
      end
      PUSH_B: begin
        cmd.push  = 1'b1;
        state_nxt = POP;
      end
      POP: begin
        if (sts.stack_empty) begin
          state_nxt = char_mode_r ? SCAN_NEXT : COMMIT;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = CUR_RD;
        end
      end
      CUR_RD: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = CUR_CHK;
      end
      CUR_CHK: begin
        if (sts.split) begin
          cmd.cand_n1 = 1'b1;
          state_nxt   = PUSH_A;
        end else begin
          cmd.keep  = 1'b1;
          state_nxt = POP;
        end
      end
      COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = IDLE;
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= IDLE;
      char_mode_r  <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      char_mode_r  <= char_mode_nxt;
      out_strobe_r <= (state_r == COMMIT);
    end
  end

endmodule

// ===== hdl/nrm_datapath.sv =====
// Datapath of the NFA regex match step block: entry table, closure stack,
// active, next and visited sets, and the result registers. Depends on nrm_pkg.
module nrm_datapath import nrm_pkg::*; #(
  parameter int NFA_STATES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_wdata,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic [SYM_W-1:0]  in_entry_symbol,
  input  logic [SUCC_W-1:0] in_entry_next1,
  input  logic [SUCC_W-1:0] in_entry_next2,
  input  logic [7:0]        in_char_in,
  input  nrm_cmd_t          cmd,
  output nrm_sts_t          sts,
  output logic              out_matched,
  output logic              out_any_active
);

  localparam int IW = $clog2(NFA_STATES);
  localparam int XW = (IW > SUCC_W) ? IW : SUCC_W;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [SUCC_W-1:0] n1;
    logic [SUCC_W-1:0] n2;
  } entry_t;

  entry_t          tbl_mem [NFA_STATES];
  entry_t          tbl_q_r;
  logic [IW-1:0]   stack_mem [NFA_STATES];
  logic [IW-1:0]   cur_r;
  logic [IW:0]     top_r;
  logic [IW:0]     top_dec;
  logic [IW-1:0]   scan_r;
  logic [IW-1:0]   rd_addr;
  logic [SUCC_W-1:0] cand_r;
  logic [XW-1:0]   cand_x;
  logic [IW-1:0]   cand_idx;
  logic            cand_ok;
  logic [XW-1:0]   load_x;
  logic [IW-1:0]   load_idx;
  logic            load_ok;
  logic [7:0]      char_r;
  logic [IDX_W-1:0] start_state_r;
  logic [NFA_STATES-1:0] active_r;
  logic [NFA_STATES-1:0] next_r;
  logic [NFA_STATES-1:0] visited_r;
  logic            match_f_r;
  logic            any_f_r;
  logic            out_matched_r;
  logic            out_any_r;

  assign cand_x   = XW'(cand_r);
  assign cand_idx = cand_x[IW-1:0];
  assign cand_ok  = (int'(cand_r) < NFA_STATES) && !visited_r[cand_idx];
  assign load_x   = XW'(in_entry_index);
  assign load_idx = load_x[IW-1:0];
  assign load_ok  = (int'(in_entry_index) < NFA_STATES);
  assign top_dec  = top_r - 1'b1;
  assign rd_addr  = cmd.rd_cur ? cur_r : scan_r;

  assign sts.stack_empty = (top_r == '0);
  assign sts.split       = (tbl_q_r.sym == SYM_SPLIT);
  assign sts.scan_last   = (scan_r == IW'(NFA_STATES - 1));
  assign sts.hit         = active_r[scan_r] &&
                           ((tbl_q_r.sym == {1'b0, char_r}) || (tbl_q_r.sym == SYM_WILD));

  assign out_matched    = out_matched_r;
  assign out_any_active = out_any_r;

  // Entry table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      tbl_mem[load_idx] <= '{sym: in_entry_symbol, n1: in_entry_next1, n2: in_entry_next2};
    end
    if (cmd.rd_scan || cmd.rd_cur) begin
      tbl_q_r <= tbl_mem[rd_addr];
    end
  end

  // Closure work stack. Visited marks keep it from holding more than the
  // table depth.
  always_ff @(posedge clk) begin
    if (cmd.push && cand_ok) begin
      stack_mem[top_r[IW-1:0]] <= cand_idx;
    end
    if (cmd.pop) begin
      cur_r <= stack_mem[top_dec[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      char_r <= in_char_in;
    end
    if (cmd.cand_start) begin
      cand_r <= SUCC_W'(start_state_r);
    end else if (cmd.cand_n1) begin
      cand_r <= tbl_q_r.n1;
    end else if (cmd.cand_n2) begin
      cand_r <= tbl_q_r.n2;
    end
    if (cmd.commit) begin
      out_matched_r <= match_f_r;
      out_any_r     <= any_f_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_state_r <= '0;
      active_r      <= '0;
      next_r        <= '0;
      visited_r     <= '0;
      top_r         <= '0;
      scan_r        <= '0;
      match_f_r     <= 1'b0;
      any_f_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        start_state_r <= cfg_wdata;
      end
      if (cmd.clear) begin
        next_r    <= '0;
        visited_r <= '0;
        top_r     <= '0;
        scan_r    <= '0;
        match_f_r <= 1'b0;
        any_f_r   <= 1'b0;
      end
      if (cmd.push && cand_ok) begin
        visited_r[cand_idx] <= 1'b1;
        top_r               <= top_r + 1'b1;
      end
      if (cmd.pop) begin
        top_r <= top_dec;
      end
      if (cmd.scan_inc) begin
        scan_r <= scan_r + 1'b1;
      end
      // Split entries are only followed; every other entry reached joins the set.
      if (cmd.keep) begin
        next_r[cur_r] <= 1'b1;
        any_f_r       <= 1'b1;
        if (tbl_q_r.sym == SYM_MATCH) begin
          match_f_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        active_r <= next_r;
      end
    end
  end

endmodule

// ===== hdl/nfa_regex_match_step_top.sv =====
// Top level of the NFA regex match step block.
// Joins nrm_ctrl and nrm_datapath; depends on nrm_pkg.
//
// Use: write the start entry index through cfg_we/cfg_wdata while the block is
// idle. Drive an item on the in_ ports and raise start; it transfers at a rising
// edge where start is high and busy is low. A load item writes one table entry
// in its transfer cycle and gives no result. A start item or a character item
// raises busy and later gives one result: out_matched and out_any_active are
// valid for exactly one cycle while out_strobe is high. The receiver cannot
// stall, so a result is never held. The next item may transfer in the cycle
// that shows the strobe. Action 3 is taken and does nothing.
// A start item runs the closure from the start entry; a character item scans
// every table entry, and each active entry that advances starts a closure
// from its first successor. The scan reads the entry table once per entry
// through its single read port, and each closure step reads it again.
// Reset clears the active set, the start index and the controller; the table
// holds nothing until loaded.
module nfa_regex_match_step_top import nrm_pkg::*; #(
  parameter int NFA_STATES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_wdata,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_action,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic [SYM_W-1:0]  in_entry_symbol,
  input  logic [SUCC_W-1:0] in_entry_next1,
  input  logic [SUCC_W-1:0] in_entry_next2,
  input  logic [7:0]        in_char_in,
  output logic              out_strobe,
  output logic              out_matched,
  output logic              out_any_active
);

  nrm_cmd_t cmd;
  nrm_sts_t sts;

  nrm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_action  (in_action),
    .sts        (sts),
    .busy       (busy),
    .cmd        (cmd),
    .out_strobe (out_strobe)
  );

  nrm_datapath #(
    .NFA_STATES (NFA_STATES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_entry_index  (in_entry_index),
    .in_entry_symbol (in_entry_symbol),
    .in_entry_next1  (in_entry_next1),
    .in_entry_next2  (in_entry_next2),
    .in_char_in      (in_char_in),
    .cmd             (cmd),
    .sts             (sts),
    .out_matched     (out_matched),
    .out_any_active  (out_any_active)
  );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for nfa_regex_match_step_top: loads NFA tables, starts
// matches and feeds bytes, predicting matched/any_active per result transfer.
// Depends on nrm_pkg and the RTL under hdl/.
module tb;
  import nrm_pkg::*;

  localparam int NFA_STATES = 64;
  localparam logic [1:0] ACT_NOP = 2'd3;
  localparam logic [7:0] CHAR_A = 8'h61;
  // Worst case of one character item: full scan, every entry advancing and
  // every entry entered by the closure as a split.
  localparam int MAX_LATENCY = 1 + 3 * NFA_STATES + 2 * NFA_STATES + 5 * NFA_STATES;
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 170;

  typedef struct packed {
    logic [1:0]        act;
    logic [IDX_W-1:0]  idx;
    logic [SYM_W-1:0]  sym;
    logic [SUCC_W-1:0] n1;
    logic [SUCC_W-1:0] n2;
    logic [7:0]        ch;
  } nfa_item_t;

  typedef struct packed {
    logic matched;
    logic any_active;
  } match_flags_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_wdata;
  logic              start;
  logic              busy;
  logic [1:0]        in_action;
  logic [IDX_W-1:0]  in_entry_index;
  logic [SYM_W-1:0]  in_entry_symbol;
  logic [SUCC_W-1:0] in_entry_next1;
  logic [SUCC_W-1:0] in_entry_next2;
  logic [7:0]        in_char_in;
  logic              out_strobe;
  logic              out_matched;
  logic              out_any_active;

  nfa_item_t    pending_items[$];
  match_flags_t expected_flags[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  bit           no_gaps = 1'b0;

  // Predictor state.
  logic [SYM_W-1:0]      sym_tbl [NFA_STATES];
  logic [SUCC_W-1:0]     next1_tbl [NFA_STATES];
  logic [SUCC_W-1:0]     next2_tbl [NFA_STATES];
  logic [NFA_STATES-1:0] live_set;
  logic [NFA_STATES-1:0] reach_set;
  logic [NFA_STATES-1:0] seen_set;
  logic [IDX_W-1:0]      start_idx;

  nfa_regex_match_step_top #(.NFA_STATES(NFA_STATES)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_entry_index (in_entry_index),
    .in_entry_symbol(in_entry_symbol),
    .in_entry_next1 (in_entry_next1),
    .in_entry_next2 (in_entry_next2),
    .in_char_in     (in_char_in),
    .out_strobe     (out_strobe),
    .out_matched    (out_matched),
    .out_any_active (out_any_active)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Follows split entries from one entry; every entry is entered at most once
  // per item, and splits are never kept in the reached set.
  function automatic void close_over_splits(input int first);
    int stack[$];
    int cur;
    if (first >= NFA_STATES || seen_set[first]) return;
    seen_set[first] = 1'b1;
    stack.push_back(first);
    while (stack.size() > 0) begin
      cur = stack.pop_back();
      if (sym_tbl[cur] == SYM_SPLIT) begin
        if (next1_tbl[cur] < NFA_STATES && !seen_set[next1_tbl[cur]]) begin
          seen_set[next1_tbl[cur]] = 1'b1;
          stack.push_back(next1_tbl[cur]);
        end
        if (next2_tbl[cur] < NFA_STATES && !seen_set[next2_tbl[cur]]) begin
          seen_set[next2_tbl[cur]] = 1'b1;
          stack.push_back(next2_tbl[cur]);
        end
      end else begin
        reach_set[cur] = 1'b1;
      end
    end
  endfunction

  // Applies one transferred item; returns 1 when it produces a result.
  function automatic bit advance_nfa(input nfa_item_t it, output match_flags_t res);
    res = '0;
    if (it.act == ACT_LOAD) begin
      sym_tbl[it.idx] = it.sym;
      next1_tbl[it.idx] = it.n1;
      next2_tbl[it.idx] = it.n2;
      return 1'b0;
    end
    if (it.act == ACT_NOP) return 1'b0;
    reach_set = '0;
    seen_set = '0;
    if (it.act == ACT_START) begin
      close_over_splits(start_idx);
    end else begin
      for (int i = 0; i < NFA_STATES; i++) begin
        if (live_set[i] && (sym_tbl[i] == {1'b0, it.ch} || sym_tbl[i] == SYM_WILD))
          close_over_splits(next1_tbl[i]);
      end
    end
    live_set = reach_set;
    res.any_active = |live_set;
    for (int i = 0; i < NFA_STATES; i++) begin
      if (live_set[i] && sym_tbl[i] == SYM_MATCH) res.matched = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic nfa_item_t load_item(input int idx, input int sym, input int n1,
                                          input int n2);
    nfa_item_t it;
    it.act = ACT_LOAD;
    it.idx = IDX_W'(idx);
    it.sym = SYM_W'(sym);
    it.n1 = SUCC_W'(n1);
    it.n2 = SUCC_W'(n2);
    it.ch = 8'($urandom);
    return it;
  endfunction

  // Start, character and unused items carry random junk in the load fields.
  function automatic nfa_item_t op_item(input logic [1:0] act, input int ch);
    nfa_item_t it;
    it.act = act;
    it.idx = IDX_W'($urandom);
    it.sym = SYM_W'($urandom);
    it.n1 = SUCC_W'($urandom);
    it.n2 = SUCC_W'($urandom);
    it.ch = 8'(ch);
    return it;
  endfunction

  // Successors mostly point a little ahead, second successors a little back,
  // so that random tables form chains and loops through split entries.
  function automatic nfa_item_t random_entry(input int idx);
    int r;
    int sym;
    int n1;
    int n2;
    r = $urandom_range(99);
    if (r < 35) sym = CHAR_A + $urandom_range(2);
    else if (r < 45) sym = SYM_WILD;
    else if (r < 70) sym = SYM_SPLIT;
    else if (r < 80) sym = SYM_MATCH;
    else if (r < 85) sym = $urandom_range(511, 258);
    else sym = $urandom_range(255);
    r = $urandom_range(99);
    if (r < 75) n1 = (idx + $urandom_range(3, 1)) % NFA_STATES;
    else if (r < 90) n1 = $urandom_range(NFA_STATES - 1);
    else n1 = $urandom_range(127, NFA_STATES);
    r = $urandom_range(99);
    if (r < 60) n2 = (idx + NFA_STATES - $urandom_range(3)) % NFA_STATES;
    else if (r < 85) n2 = $urandom_range(NFA_STATES - 1);
    else n2 = $urandom_range(127, NFA_STATES);
    return load_item(idx, sym, n1, n2);
  endfunction

  task automatic queue_random_program();
    for (int i = 0; i < NFA_STATES; i++) pending_items.push_back(random_entry(i));
  endtask

  // Waits until every queued item has transferred and every result has come,
  // then lets a few cycles pass for items that give no result.
  task automatic wait_idle();
    while (pending_items.size() > 0 || expected_flags.size() > 0 || start || busy)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_start_index(input logic [IDX_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    start_idx = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Driver: holds an item until it transfers, then picks the next one.
  always @(posedge clk) begin : drive
    nfa_item_t    nxt;
    nfa_item_t    sent;
    match_flags_t flags;
    if (!rst_n) begin
      start <= 1'b0;
      in_action <= ACT_LOAD;
      in_entry_index <= '0;
      in_entry_symbol <= '0;
      in_entry_next1 <= '0;
      in_entry_next2 <= '0;
      in_char_in <= '0;
      live_set = '0;
    end else begin
      if (start && !busy) begin
        sent = {in_action, in_entry_index, in_entry_symbol, in_entry_next1,
                in_entry_next2, in_char_in};
        if (advance_nfa(sent, flags)) expected_flags.push_back(flags);
      end
      if (!start || !busy) begin
        if (pending_items.size() > 0 && (no_gaps || $urandom_range(99) >= 19)) begin
          nxt = pending_items.pop_front();
          in_action <= nxt.act;
          in_entry_index <= nxt.idx;
          in_entry_symbol <= nxt.sym;
          in_entry_next1 <= nxt.n1;
          in_entry_next2 <= nxt.n2;
          in_char_in <= nxt.ch;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe is one result transfer.
  always @(posedge clk) begin : observe
    match_flags_t want;
    if (rst_n && out_strobe) begin
      if (expected_flags.size() == 0) begin
        $error("unexpected result: matched=%0b any_active=%0b", out_matched,
               out_any_active);
        mismatch_count++;
      end else begin
        want = expected_flags.pop_front();
        if (out_matched !== want.matched) begin
          $error("matched: expected %0b, got %0b", want.matched, out_matched);
          mismatch_count++;
        end
        if (out_any_active !== want.any_active) begin
          $error("any_active: expected %0b, got %0b", want.any_active, out_any_active);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int r;
    int k;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    start_idx = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The whole table is loaded first so that no entry is read
    // before it has been written.
    write_start_index('0);
    queue_random_program();
    pending_items.push_back(load_item(0, SYM_SPLIT, 1, 3));
    pending_items.push_back(load_item(1, CHAR_A, 2, 0));
    pending_items.push_back(load_item(2, SYM_MATCH, NFA_STATES, NFA_STATES));
    pending_items.push_back(load_item(3, SYM_WILD, 4, 127));
    pending_items.push_back(load_item(4, 255, 5, 0));
    pending_items.push_back(load_item(5, 0, 2, 0));
    pending_items.push_back(load_item(63, 511, 127, 127));
    pending_items.push_back(op_item(ACT_START, 0));
    pending_items.push_back(op_item(ACT_CHAR, CHAR_A));
    pending_items.push_back(op_item(ACT_CHAR, 255));
    pending_items.push_back(op_item(ACT_CHAR, 0));
    pending_items.push_back(op_item(ACT_CHAR, 8'h78));
    pending_items.push_back(op_item(ACT_CHAR, CHAR_A));
    pending_items.push_back(op_item(ACT_NOP, 255));
    // A split that only loops back to itself closes to an empty set.
    pending_items.push_back(load_item(0, SYM_SPLIT, NFA_STATES, 0));
    pending_items.push_back(op_item(ACT_START, 0));
    // An entry with an unused symbol is entered but matches no byte, so the set empties.
    pending_items.push_back(load_item(0, SYM_SPLIT, 63, 127));
    pending_items.push_back(op_item(ACT_START, 0));
    pending_items.push_back(op_item(ACT_CHAR, 255));
    // A wildcard looping to itself survives any byte.
    pending_items.push_back(load_item(0, SYM_WILD, 0, NFA_STATES));
    pending_items.push_back(op_item(ACT_START, 0));
    pending_items.push_back(op_item(ACT_CHAR, $urandom_range(255)));
    pending_items.push_back(op_item(ACT_CHAR, SYM_WILD[7:0]));
    wait_idle();

    // Random phases: each gets a new start index and a fresh table, then
    // matches over a small alphabet with some noise mixed in.
    for (int ph = 0; ph < PHASES; ph++) begin
      no_gaps = (ph == 2);
      if (ph == 0) write_start_index(IDX_W'(NFA_STATES - 1));
      else if (ph == PHASES - 1) write_start_index('0);
      else write_start_index(IDX_W'($urandom_range(NFA_STATES - 1)));
      queue_random_program();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(99);
        if (r < 8) begin
          pending_items.push_back(op_item(ACT_START, $urandom));
        end else if (r < 12) begin
          pending_items.push_back(random_entry($urandom_range(NFA_STATES - 1)));
        end else if (r < 15) begin
          pending_items.push_back(op_item(ACT_NOP, $urandom));
        end else if (r < 22) begin
          pending_items.push_back(op_item(ACT_CHAR, $urandom_range(255)));
        end else begin
          k = $urandom_range(3);
          pending_items.push_back(op_item(ACT_CHAR, (k == 3) ? SYM_WILD[7:0] : CHAR_A + k));
        end
      end
      wait_idle();
    end
    no_gaps = 1'b0;

    repeat (MAX_LATENCY) @(posedge clk);
    if (expected_flags.size() != 0) begin
      $error("%0d expected results never arrived", expected_flags.size());
    end
    if (mismatch_count == 0 && expected_flags.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/nrm_pkg.sv
hdl/nrm_ctrl.sv
hdl/nrm_datapath.sv
hdl/nfa_regex_match_step_top.sv
verif/tb.sv
